/* hdl/vdi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg: shared types and constants of the vertex deduplication indexer
// Holds the table size, the vertex record, the controller states and the
// result record that the group encoders hand to the top level.
// ----------------------------------------------------------------------------
package vdi_pkg;

	// Number of vertices the table can hold (valid range 2 .. 256).
	localparam int MAX_VERTICES = 256;

	// Slot address and fill-count widths follow from the table size.
	localparam int SLOT_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

	// Cells are encoded in groups of sixteen, then the groups are combined.
	localparam int GRP_SIZE = 16;
	localparam int GRP_W    = $clog2(GRP_SIZE);
	localparam int NGRP     = (MAX_VERTICES + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GIDX_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int KPOS_W   = GIDX_W + GRP_W;

	// Coordinate and record widths.
	localparam int COORD_W  = 32;
	localparam int VERTEX_W = 3 * COORD_W;

	// Action codes of an input beat.
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vertex_t;

	// Registered result of one group encoder.
	typedef struct packed {
		logic             hit;
		logic [GRP_W-1:0] sub;
	} grp_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_FIN
	} state_t;

endpackage

/* hdl/vdi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vdi_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/vdi_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_cell: one storage and compare cell of the vertex chain
// Holds one vertex, passes it to the next cell when a vertex is appended, and
// registers an exact match against the incoming key.
// ----------------------------------------------------------------------------
module vdi_cell import vdi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  vertex_t shift_in,
	input  logic    cmp_en,
	input  vertex_t key,
	input  logic    occupied,
	output vertex_t vertex,
	output logic    hit
);

	vertex_t vertex_q;
	logic    hit_q;

	// On an append cell 0 takes the new key and every other cell takes its left neighbor's vertex.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			vertex_q <= shift_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmp_en) begin
			hit_q <= occupied && (vertex_q == key);
		end
	end

	assign vertex = vertex_q;
	assign hit    = hit_q;

endmodule

/* hdl/vdi_grp_enc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_grp_enc: registered match encoder for one group of cells
// Reduces sixteen match flags to a hit flag and the position of the hit.
// ----------------------------------------------------------------------------
module vdi_grp_enc import vdi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [GRP_SIZE-1:0] hits,
	output grp_res_t            res
);

	grp_res_t res_d;
	grp_res_t res_q;

	// Stored vertices are distinct, so at most one flag is set and an OR
	// of the positions gives the encoded index.
	always_comb begin
		res_d = '0;
		for (int i = 0; i < GRP_SIZE; i++) begin
			if (hits[i]) begin
				res_d.hit = 1'b1;
				res_d.sub = res_d.sub | GRP_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

/* hdl/vertex_dedup_indexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: deduplicating vertex index table
// Turns a stream of triangle-corner vertices into indexes of distinct
// vertices, and reads stored vertices back by slot.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  --------------------------------------------
//  input    in_valid / in_stall  action, coord_x, coord_y, coord_z, read_slot
//  output   out_valid/ out_stall vertex_index, is_new, table_overflow,
//                                read_valid, out_x, out_y, out_z,
//                                unique_count, corner_count
//
//  Every input beat passes the accept edge (all cells compare the key in
//  parallel and the read memory is addressed), the group encoders, and the
//  finishing cycle that combines the groups.
//  One item is in work at a time, so the next beat is accepted only once
//  the previous one has left the finishing cycle.
//  A finished result waits in the output register; the next beat is accepted
//  meanwhile, and it only holds in its finishing cycle if the older result
//  has still not been taken.
//  Reset clears the fill count, the corner count and all handshake state; the
//  vertex cells and the read memory need no clearing since only slots below
//  the fill count are ever matched or read.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer import vdi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [7:0]         read_slot,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         vertex_index,
	output logic               is_new,
	output logic               table_overflow,
	output logic               read_valid,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [8:0]         unique_count,
	output logic [31:0]        corner_count
);

	// Width used to compare the requested slot against the fill count.
	localparam int RD_W = (CNT_W > 8) ? CNT_W : 8;

	state_t state_q, state_d;

	logic        in_beat;
	logic        fire;
	vertex_t     key_in;
	vertex_t     key_q;
	logic        action_q;
	logic        rd_ok_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0] corner_q;

	// Vertex chain.
	vertex_t                    cell_v [MAX_VERTICES];
	logic [NGRP*GRP_SIZE-1:0]   hit_vec;
	logic                       shift_en;
	grp_res_t                   grp_res [NGRP];
	logic [NGRP-1:0]            grp_hits;

	// Finishing logic.
	logic              any_hit;
	logic [KPOS_W-1:0] hit_pos;
	logic [CNT_W-1:0]  hit_index;
	logic              tbl_full;
	logic              append;

	vertex_t rd_data;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  vertex_index_q;
	logic        is_new_q;
	logic        table_overflow_q;
	logic        read_valid_q;
	vertex_t     out_v_q;
	logic [8:0]  unique_count_q;
	logic [31:0] corner_count_q;

	assign in_beat = in_valid && !in_stall;
	assign key_in  = '{x: coord_x, y: coord_y, z: coord_z};

	// The finishing cycle completes once the output register is free.
	assign fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// ------------------------------------------------------------------
	// Controller
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_ENC;
				end
			end
			ST_ENC: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Beat capture: the key for the append and the read bounds check.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			key_q    <= key_in;
			action_q <= action;
			rd_ok_q  <= RD_W'(read_slot) < RD_W'(count_q);
		end
	end

	// ------------------------------------------------------------------
	// Cell chain: newest vertex sits in cell 0, so cell k holds the vertex
	// with index count - 1 - k. Cells at or beyond the count are empty.
	// ------------------------------------------------------------------
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		vdi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.shift_in ((k == 0) ? key_q : cell_v[(k == 0) ? 0 : k - 1]),
			.cmp_en   (in_beat),
			.key      (key_in),
			.occupied (CNT_W'(k) < count_q),
			.vertex   (cell_v[k]),
			.hit      (hit_vec[k])
		);
	end

	// Pad the last group when the table size is not a multiple of sixteen.
	if (NGRP * GRP_SIZE > MAX_VERTICES) begin : g_pad
		assign hit_vec[NGRP*GRP_SIZE-1:MAX_VERTICES] = '0;
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		vdi_grp_enc u_enc (
			.clk    (clk),
			.arst_n (arst_n),
			.hits   (hit_vec[g*GRP_SIZE +: GRP_SIZE]),
			.res    (grp_res[g])
		);
		assign grp_hits[g] = grp_res[g].hit;
	end

	// Combine the group results; at most one group reports a hit.
	always_comb begin
		any_hit = 1'b0;
		hit_pos = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_res[g].hit) begin
				any_hit = 1'b1;
				hit_pos = hit_pos | (KPOS_W'(g) << GRP_W) | KPOS_W'(grp_res[g].sub);
			end
		end
	end

	assign hit_index = count_q - CNT_W'(1) - CNT_W'(hit_pos);
	assign tbl_full  = (count_q == CNT_W'(MAX_VERTICES));
	assign append    = fire && (action_q == ACT_INSERT) && !any_hit && !tbl_full;
	assign shift_en  = append;

	// ------------------------------------------------------------------
	// Slot-addressed copy of the table for reads.
	// ------------------------------------------------------------------
	vdi_ram #(
		.WIDTH (VERTEX_W),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (append),
		.waddr (count_q[SLOT_W-1:0]),
		.wdata (key_q),
		.re    (in_beat),
		.raddr (SLOT_W'(read_slot)),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------
	// Table counters.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			corner_q <= '0;
		end else if (fire && (action_q == ACT_INSERT)) begin
			if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (corner_q != '1) begin
				corner_q <= corner_q + 32'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			vertex_index_q   <= '0;
			is_new_q         <= 1'b0;
			table_overflow_q <= 1'b0;
			read_valid_q     <= 1'b0;
			out_v_q          <= '0;
			unique_count_q   <= 9'(count_q);
			corner_count_q   <= corner_q;
			if (action_q == ACT_INSERT) begin
				if (corner_q != '1) begin
					corner_count_q <= corner_q + 32'd1;
				end
				if (any_hit) begin
					vertex_index_q <= 8'(hit_index);
				end else if (!tbl_full) begin
					vertex_index_q <= 8'(count_q);
					is_new_q       <= 1'b1;
					unique_count_q <= 9'(count_q + CNT_W'(1));
				end else begin
					table_overflow_q <= 1'b1;
				end
			end else if (rd_ok_q) begin
				read_valid_q <= 1'b1;
				out_v_q      <= rd_data;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign vertex_index   = vertex_index_q;
	assign is_new         = is_new_q;
	assign table_overflow = table_overflow_q;
	assign read_valid     = read_valid_q;
	assign out_x          = out_v_q.x;
	assign out_y          = out_v_q.y;
	assign out_z          = out_v_q.z;
	assign unique_count   = unique_count_q;
	assign corner_count   = corner_count_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// Stored vertices are distinct, so no two groups may report a hit.
	a_grp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> $onehot0(grp_hits))
		else $error("more than one group matched the key");

	// The fill count never passes the table size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("fill count beyond table size");

	// A freshly appended vertex takes the slot just below the new fill count.
	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_new) |-> (vertex_index == 8'(unique_count - 9'd1)))
		else $error("new vertex index does not match the fill count");

	// A result never flags both an append and an overflow.
	a_new_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && table_overflow))
		else $error("result flags both new vertex and overflow");

	// An append only happens in the finishing cycle of an insert.
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |-> ((state_q == ST_FIN) && (action_q == ACT_INSERT)))
		else $error("append outside the finishing cycle of an insert");

endmodule
